### rtl/core/assert_macros.svh
// Assertion macros for the allocator RTL.
// Define NO_ASSERTIONS to compile every check away.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef NO_ASSERTIONS
// property that must hold at every rising edge outside reset
`define ASSERT_AT(lbl, clk, rst_n, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
// condition that must never be seen at a rising edge outside reset
`define ASSERT_NEVER(lbl, clk, rst_n, expr, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) else $error(msg);
`else
`define ASSERT_AT(lbl, clk, rst_n, prop, msg)
`define ASSERT_NEVER(lbl, clk, rst_n, expr, msg)
`endif
`endif

### rtl/core/ibma_pkg.sv
// Shared types for the id bitmap allocator: controller states, command and status bundles.
// Used by ibma_ctrl, ibma_dp and the top level; no dependencies.
package ibma_pkg;

	// bitmap row stored per RAM word
	localparam int ROW_W = 32;
	localparam int ROW_B = 5;

	typedef enum logic [2:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_START,
		ST_TGT_CHK,
		ST_SCAN_RD,
		ST_SCAN_CHK,
		ST_FINISH
	} state_t;

	// controller -> datapath
	typedef struct packed {
		logic latch;       // capture the input transaction
		logic rd_en;       // read one bitmap row
		logic rd_scan;     // row address from scan counter (else target id)
		logic scan_start;  // scan counter to row 0
		logic scan_next;   // scan counter + 1
		logic clr_wr;      // write zero row at scan counter
		logic pick_target; // result = target id, toggle its bit
		logic pick_scan;   // result = lowest free id of scanned row
		logic pick_fail;   // result = not granted
		logic commit;      // write row, update count/hint, load output
	} cmd_t;

	// datapath -> controller
	typedef struct packed {
		logic op_rel;     // latched op is release
		logic hint_ok;    // hint below id range end
		logic rid_ok;     // release id in range
		logic target_bit; // bitmap bit of target id from last read
		logic row_free;   // scanned row holds a free valid id
		logic last_row;   // scan counter at last row
		logic out_free;   // output register can take a result
	} sts_t;

endpackage

### rtl/core/ibma_ram.sv
// Generic simple dual-port RAM: one write port, one read port with registered data.
// No dependencies.
module ibma_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 2,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic             re,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

### rtl/core/ibma_ctrl.sv
// Controller FSM of the id bitmap allocator: sequences clear, lookup, scan and commit.
// Depends on ibma_pkg.
module ibma_ctrl (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          in_valid,
	output logic          in_ready,
	input  ibma_pkg::sts_t sts,
	output ibma_pkg::cmd_t cmd
);

	import ibma_pkg::*;

	state_t state_q;
	state_t state_nxt;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLEAR;
		end else begin
			state_q <= state_nxt;
		end
	end

	// next state
	always_comb begin
		state_nxt = state_q;
		unique case (state_q)
			ST_CLEAR: begin
				if (sts.last_row) state_nxt = ST_IDLE;
			end
			ST_IDLE: begin
				if (in_valid) state_nxt = ST_START;
			end
			ST_START: begin
				priority if (sts.op_rel && !sts.rid_ok) state_nxt = ST_FINISH;
				else if (!sts.op_rel && !sts.hint_ok) state_nxt = ST_SCAN_RD;
				else state_nxt = ST_TGT_CHK;
			end
			ST_TGT_CHK: begin
				if (!sts.op_rel && sts.target_bit) state_nxt = ST_SCAN_RD;
				else state_nxt = ST_FINISH;
			end
			ST_SCAN_RD: state_nxt = ST_SCAN_CHK;
			ST_SCAN_CHK: begin
				if (sts.row_free || sts.last_row) state_nxt = ST_FINISH;
				else state_nxt = ST_SCAN_RD;
			end
			ST_FINISH: begin
				if (sts.out_free) state_nxt = ST_IDLE;
			end
			default: state_nxt = ST_IDLE;
		endcase
	end

	// outputs
	always_comb begin
		cmd      = '0;
		in_ready = 1'b0;
		unique case (state_q)
			ST_CLEAR: begin
				cmd.clr_wr    = 1'b1;
				cmd.scan_next = 1'b1;
			end
			ST_IDLE: begin
				in_ready  = 1'b1;
				cmd.latch = in_valid;
			end
			ST_START: begin
				priority if (sts.op_rel && !sts.rid_ok) cmd.pick_fail = 1'b1;
				else if (!sts.op_rel && !sts.hint_ok) cmd.scan_start = 1'b1;
				else cmd.rd_en = 1'b1;
			end
			ST_TGT_CHK: begin
				priority if (!sts.op_rel && sts.target_bit) cmd.scan_start = 1'b1;
				else if (sts.op_rel && !sts.target_bit) cmd.pick_fail = 1'b1;
				else cmd.pick_target = 1'b1;
			end
			ST_SCAN_RD: begin
				cmd.rd_en   = 1'b1;
				cmd.rd_scan = 1'b1;
			end
			ST_SCAN_CHK: begin
				priority if (sts.row_free) cmd.pick_scan = 1'b1;
				else if (sts.last_row) cmd.pick_fail = 1'b1;
				else cmd.scan_next = 1'b1;
			end
			ST_FINISH: begin
				cmd.commit = sts.out_free;
			end
			default: begin
				cmd = '0;
			end
		endcase
	end

endmodule

### rtl/core/ibma_dp.sv
// Datapath of the id bitmap allocator: bitmap RAM, scan counter, hint, count, output register.
// Depends on ibma_pkg, ibma_ram and assert_macros.svh.
`include "assert_macros.svh"

module ibma_dp #(
	parameter int NUM_IDS = 64,
	localparam int ID_W  = $clog2(NUM_IDS),
	localparam int CNT_W = $clog2(NUM_IDS + 1)
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_func,
	input  logic [ID_W-1:0]  in_rid,
	output logic             out_valid,
	input  logic             out_ready,
	output logic             out_ok,
	output logic [ID_W-1:0]  out_id,
	output logic [CNT_W-1:0] out_count,
	input  ibma_pkg::cmd_t   cmd,
	output ibma_pkg::sts_t   sts
);

	import ibma_pkg::*;

	localparam int ROWS      = (NUM_IDS + ROW_W - 1) / ROW_W;
	localparam int ROW_AW    = (ROWS > 1) ? $clog2(ROWS) : 1;
	localparam int FID_W     = ROW_AW + ROW_B;
	localparam int LAST_BITS = NUM_IDS - (ROWS - 1) * ROW_W;

	function automatic logic [ROW_B-1:0] lowest_set(input logic [ROW_W-1:0] v);
		logic [ROW_B-1:0] r;
		r = '0;
		for (int i = ROW_W - 1; i >= 0; i--) begin
			if (v[i]) r = ROW_B'(i);
		end
		return r;
	endfunction

	// latched transaction
	logic              op_q;
	logic [ID_W-1:0]   rid_q;

	// control registers
	logic [ROW_AW-1:0] scan_row_q;
	logic [CNT_W-1:0]  count_q;
	logic [CNT_W-1:0]  hint_q;
	logic              out_valid_q;

	// result of lookup, waiting for commit
	logic              res_ok_q;
	logic [FID_W-1:0]  res_id_q;
	logic [ROW_AW-1:0] wr_row_q;
	logic [ROW_W-1:0]  wr_data_q;

	// output payload
	logic              out_ok_q;
	logic [ID_W-1:0]   out_id_q;
	logic [CNT_W-1:0]  out_count_q;

	logic [ROW_W-1:0]  rd_data;
	logic [FID_W-1:0]  tgt_fid;
	logic [ROW_AW-1:0] tgt_row;
	logic [ROW_B-1:0]  tgt_bit;
	logic [ROW_W-1:0]  tgt_new;
	logic [ROW_W-1:0]  row_mask;
	logic [ROW_W-1:0]  free_vec;
	logic [ROW_B-1:0]  free_bit;
	logic [ROW_W-1:0]  scan_new;
	logic              last_row;
	logic              out_free;
	logic [CNT_W-1:0]  count_nxt;
	logic [CNT_W-1:0]  hint_nxt;

	logic              ram_we;
	logic [ROW_AW-1:0] ram_waddr;
	logic [ROW_W-1:0]  ram_wdata;
	logic [ROW_AW-1:0] ram_raddr;

	assign tgt_fid = op_q ? FID_W'(rid_q) : FID_W'(hint_q[ID_W-1:0]);
	assign tgt_row = tgt_fid[FID_W-1:ROW_B];
	assign tgt_bit = tgt_fid[ROW_B-1:0];

	always_comb begin
		tgt_new          = rd_data;
		tgt_new[tgt_bit] = !op_q;
	end

	assign last_row = (scan_row_q == ROW_AW'(ROWS - 1));

	// ids past the range end in the last row never count as free
	always_comb begin
		for (int b = 0; b < ROW_W; b++) begin
			row_mask[b] = !last_row || (b < LAST_BITS);
		end
	end

	assign free_vec = ~rd_data & row_mask;
	assign free_bit = lowest_set(free_vec);

	always_comb begin
		scan_new           = rd_data;
		scan_new[free_bit] = 1'b1;
	end

	assign out_free = !out_valid_q || out_ready;

	always_comb begin
		count_nxt = count_q;
		hint_nxt  = hint_q;
		if (op_q) begin
			if (res_ok_q) count_nxt = count_q - CNT_W'(1);
		end else if (res_ok_q) begin
			count_nxt = count_q + CNT_W'(1);
			hint_nxt  = CNT_W'(res_id_q) + CNT_W'(1);
		end else begin
			hint_nxt = CNT_W'(NUM_IDS);
		end
	end

	assign sts.op_rel     = op_q;
	assign sts.hint_ok    = hint_q < CNT_W'(NUM_IDS);
	assign sts.rid_ok     = (ID_W + 1)'(rid_q) < (ID_W + 1)'(NUM_IDS);
	assign sts.target_bit = rd_data[tgt_bit];
	assign sts.row_free   = |free_vec;
	assign sts.last_row   = last_row;
	assign sts.out_free   = out_free;

	assign ram_we    = cmd.clr_wr || (cmd.commit && res_ok_q);
	assign ram_waddr = cmd.clr_wr ? scan_row_q : wr_row_q;
	assign ram_wdata = cmd.clr_wr ? '0 : wr_data_q;
	assign ram_raddr = cmd.rd_scan ? scan_row_q : tgt_row;

	ibma_ram #(
		.WIDTH (ROW_W),
		.DEPTH (ROWS)
	) u_map (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.re    (cmd.rd_en),
		.raddr (ram_raddr),
		.rdata (rd_data)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			scan_row_q  <= '0;
			count_q     <= '0;
			hint_q      <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cmd.scan_start) begin
				scan_row_q <= '0;
			end else if (cmd.scan_next) begin
				scan_row_q <= scan_row_q + ROW_AW'(1);
			end
			if (cmd.commit) begin
				count_q     <= count_nxt;
				hint_q      <= hint_nxt;
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.latch) begin
			op_q  <= in_func;
			rid_q <= in_rid;
		end
		// pick commands are one-hot; most cycles carry none of them
		if (cmd.pick_target) begin
			res_ok_q  <= 1'b1;
			res_id_q  <= tgt_fid;
			wr_row_q  <= tgt_row;
			wr_data_q <= tgt_new;
		end else if (cmd.pick_scan) begin
			res_ok_q  <= 1'b1;
			res_id_q  <= {scan_row_q, free_bit};
			wr_row_q  <= scan_row_q;
			wr_data_q <= scan_new;
		end else if (cmd.pick_fail) begin
			res_ok_q <= 1'b0;
			res_id_q <= '0;
		end
		if (cmd.commit) begin
			out_ok_q    <= res_ok_q;
			out_id_q    <= (!op_q && res_ok_q) ? ID_W'(res_id_q) : '0;
			out_count_q <= count_nxt;
		end
	end

	assign out_valid = out_valid_q;
	assign out_ok    = out_ok_q;
	assign out_id    = out_id_q;
	assign out_count = out_count_q;

	`ASSERT_AT(a_count_range, clk, arst_n, count_q <= CNT_W'(NUM_IDS), "in-use count above id range")
	`ASSERT_AT(a_hint_range, clk, arst_n, hint_q <= CNT_W'(NUM_IDS), "hint beyond range end")
	`ASSERT_AT(a_commit_room, clk, arst_n, cmd.commit |-> out_free, "commit into full output register")
	`ASSERT_NEVER(a_rel_underflow, clk, arst_n, cmd.commit && op_q && res_ok_q && (count_q == '0), "release with zero count")

endmodule

### rtl/core/id_bitmap_allocator_unit.sv
// Id bitmap allocator: hands out ids 0 .. NUM_IDS-1 from a bitmap held in a RAM of 32-bit rows.
// Allocate tries the next-fit hint first, else scans rows from 0 for the lowest free id; release
// frees a marked id. Each input transaction gives one output transaction with ok, the granted id
// and the in-use count after the operation. After reset a clearing pass writes every row to zero,
// one row a cycle, before s_axis_tready rises. Steps per transaction, from the accepting cycle
// to the load of the output register: an allocate reads the hint row and checks the hint bit,
// then on a used hint scans rows from 0; with the hint past the range end it scans rows at once;
// a release reads and checks its id's row, and one with an id outside the range goes straight to
// the finish step. Every row inspected takes a read step and a check step, set by the single read
// port of the bitmap RAM with its registered read. One transaction is worked at a time; the output
// register lets the next transaction be accepted while a result still waits on m_axis_tready, and
// the finish step holds until that register is free.
// Depends on ibma_pkg, ibma_ctrl, ibma_dp, ibma_ram.
module id_bitmap_allocator_unit #(
	parameter int NUM_IDS = 64,
	localparam int ID_W  = $clog2(NUM_IDS),
	localparam int CNT_W = $clog2(NUM_IDS + 1),
	localparam int S_DW  = ((ID_W + 7) / 8) * 8,
	localparam int M_DW  = ((ID_W + CNT_W + 7) / 8) * 8
) (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            s_axis_tvalid,
	output logic            s_axis_tready,
	input  logic [S_DW-1:0] s_axis_tdata,  // [ID_W-1:0] release_id, rest zero fill
	input  logic            s_axis_tuser,  // func: 0 allocate, 1 release
	output logic            m_axis_tvalid,
	input  logic            m_axis_tready,
	output logic [M_DW-1:0] m_axis_tdata,  // granted_id, then in_use_count, rest zero fill
	output logic            m_axis_tuser   // ok
);

	import ibma_pkg::*;

	cmd_t cmd;
	sts_t sts;

	logic [ID_W-1:0]  res_id;
	logic [CNT_W-1:0] res_count;

	// sequencing: clear pass, hint lookup, row scan, commit
	ibma_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_axis_tvalid),
		.in_ready (s_axis_tready),
		.sts      (sts),
		.cmd      (cmd)
	);

	// bitmap RAM, hint, count and the output register
	ibma_dp #(
		.NUM_IDS (NUM_IDS)
	) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_func   (s_axis_tuser),
		.in_rid    (s_axis_tdata[ID_W-1:0]),
		.out_valid (m_axis_tvalid),
		.out_ready (m_axis_tready),
		.out_ok    (m_axis_tuser),
		.out_id    (res_id),
		.out_count (res_count),
		.cmd       (cmd),
		.sts       (sts)
	);

	assign m_axis_tdata = M_DW'({res_count, res_id});

endmodule
